@@ rtl/core/mlsp_pkg.sv @@
// ----------------------------------------------------------------------------
// mlsp_pkg
// Shared types and constants of the loopback stimulus and capture probe.
// ----------------------------------------------------------------------------
package mlsp_pkg;

  localparam int unsigned STIMULUS_LENGTH    = 1023;
  localparam int unsigned TRIAL_COUNT        = 5;
  localparam int unsigned MAX_CAPTURE_FRAMES = 4194304;

  localparam int unsigned POS_W    = 11;
  localparam int unsigned TRIALS_W = 5;
  localparam int unsigned FRAME_W  = 23;
  localparam int unsigned STRIDE_W = 25;
  localparam int unsigned TOTAL_W  = 28;
  localparam int unsigned LFSR_W   = 10;

  localparam logic [LFSR_W-1:0]  LFSR_SEED = 10'h3ff;
  localparam logic [FRAME_W-1:0] FRAME_MAX = 23'h7fffff;

  localparam logic [2:0] MODE_FRAME  = 3'd0;
  localparam logic [2:0] MODE_ARM    = 3'd1;
  localparam logic [2:0] MODE_CANCEL = 3'd2;
  localparam logic [2:0] MODE_CONFIG = 3'd3;
  localparam logic [2:0] MODE_DEVICE = 3'd4;
  localparam logic [2:0] MODE_RESET  = 3'd5;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_PREPARED  = 3'd1;
  localparam logic [2:0] ST_RUNNING   = 3'd2;
  localparam logic [2:0] ST_CAPTURED  = 3'd3;
  localparam logic [2:0] ST_DEVICE    = 3'd4;
  localparam logic [2:0] ST_CLIPPED   = 3'd5;
  localparam logic [2:0] ST_CANCELLED = 3'd6;
  localparam logic [2:0] ST_CONFIG    = 3'd7;

  localparam logic [1:0] REG_AMPLITUDE = 2'd0;
  localparam logic [1:0] REG_PRE_ROLL  = 2'd1;
  localparam logic [1:0] REG_SEARCH    = 2'd2;
  localparam logic [1:0] REG_CLIP      = 2'd3;

  typedef struct packed {
    logic [22:0] amplitude;
    logic [22:0] pre_roll;
    logic [22:0] search;
    logic [23:0] clip_level;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [23:0] raw;
    logic [23:0] mag;
    logic        clip;
  } item_t;

endpackage

@@ rtl/core/mlsp_regs.sv @@
// ----------------------------------------------------------------------------
// mlsp_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module mlsp_regs
  import mlsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.amplitude  <= 23'd4194304;
      cfg_r.pre_roll   <= 23'd2046;
      cfg_r.search     <= 23'd48000;
      cfg_r.clip_level <= 24'd8380220;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_AMPLITUDE: cfg_r.amplitude  <= pwdata[22:0];
        REG_PRE_ROLL:  cfg_r.pre_roll   <= pwdata[22:0];
        REG_SEARCH:    cfg_r.search     <= pwdata[22:0];
        REG_CLIP:      cfg_r.clip_level <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_AMPLITUDE: prdata = {9'd0, cfg_r.amplitude};
      REG_PRE_ROLL:  prdata = {9'd0, cfg_r.pre_roll};
      REG_SEARCH:    prdata = {9'd0, cfg_r.search};
      REG_CLIP:      prdata = {8'd0, cfg_r.clip_level};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/core/mlsp_front.sv @@
// ----------------------------------------------------------------------------
// mlsp_front
// Input side: takes each transfer and classifies it, magnitude and clip flag.
// ----------------------------------------------------------------------------
module mlsp_front
  import mlsp_pkg::*;
(
  input  logic        in_valid,
  input  logic [2:0]  in_mode,
  input  logic [23:0] in_sample,
  input  logic        q_full,
  input  cfg_t        cfg,
  output logic        in_stall,
  output logic        push,
  output item_t       item
);

  logic [23:0] mag;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // two's complement of the most negative code maps onto itself
  assign mag = in_sample[23] ? (~in_sample + 24'd1) : in_sample;

  always_comb begin
    item.mode = in_mode;
    item.raw  = in_sample;
    item.mag  = mag;
    item.clip = (mag >= cfg.clip_level);
  end

endmodule

@@ rtl/core/mlsp_queue.sv @@
// ----------------------------------------------------------------------------
// mlsp_queue
// Two-entry queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module mlsp_queue
  import mlsp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output item_t head
);

  item_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ rtl/core/mlsp_back.sv @@
// ----------------------------------------------------------------------------
// mlsp_back
// Probe state machine, stimulus generator and registered result stage.
// ----------------------------------------------------------------------------
module mlsp_back
  import mlsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_not_empty,
  input  item_t       q_head,
  output logic        pop,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [23:0] out_sample,
  output logic        out_capture_write,
  output logic [21:0] out_capture_address,
  output logic [23:0] out_capture_sample,
  output logic        out_arm_accepted,
  output logic [2:0]  out_probe_status,
  output logic [23:0] out_clip_peak
);

  logic [2:0]          status_r, status_nxt;
  logic [FRAME_W-1:0]  fi_r, fi_nxt;
  logic [FRAME_W-1:0]  total_r, total_nxt;
  logic [FRAME_W-1:0]  nts_r, nts_nxt;
  logic [TRIALS_W-1:0] tl_r, tl_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                em_r, em_nxt;
  logic [LFSR_W-1:0]   lfsr_r, lfsr_nxt;
  logic [23:0]         peak_r, peak_nxt;

  logic                out_valid_r;
  logic [23:0]         out_s_r, out_s_nxt;
  logic                cw_r, cw_nxt;
  logic [21:0]         caddr_r, caddr_nxt;
  logic [23:0]         csamp_r, csamp_nxt;
  logic                acc_r, acc_nxt;

  logic [STRIDE_W-1:0] stride;
  logic [STRIDE_W-1:0] nx;
  logic [TOTAL_W-1:0]  total;
  logic                active;
  logic                fb;
  logic [FRAME_W-1:0]  fi_inc;

  assign pop = q_not_empty && (!out_valid_r || !out_stall);

  assign stride = STRIDE_W'(cfg.search) + STRIDE_W'(STIMULUS_LENGTH)
                + STRIDE_W'(cfg.pre_roll);
  assign nx     = STRIDE_W'(fi_r) + stride;
  assign total  = TOTAL_W'(TRIAL_COUNT) * TOTAL_W'(stride) + TOTAL_W'(cfg.pre_roll);
  assign active = (status_r == ST_PREPARED) || (status_r == ST_RUNNING);
  assign fi_inc = fi_r + FRAME_W'(1);

  always_comb begin
    status_nxt = status_r;
    fi_nxt     = fi_r;
    total_nxt  = total_r;
    nts_nxt    = nts_r;
    tl_nxt     = tl_r;
    pos_nxt    = pos_r;
    em_nxt     = em_r;
    lfsr_nxt   = lfsr_r;
    peak_nxt   = peak_r;
    out_s_nxt  = 24'd0;
    cw_nxt     = 1'b0;
    caddr_nxt  = 22'd0;
    csamp_nxt  = 24'd0;
    acc_nxt    = 1'b0;
    fb         = 1'b0;
    case (q_head.mode)
      MODE_FRAME: begin
        if (status_nxt == ST_PREPARED) begin
          status_nxt = ST_RUNNING;
        end
        if (status_nxt == ST_RUNNING) begin
          if (fi_r >= total_r) begin
            status_nxt = ST_CAPTURED;
          end else begin
            cw_nxt    = 1'b1;
            caddr_nxt = fi_r[21:0];
            csamp_nxt = q_head.raw;
            if (q_head.clip) begin
              peak_nxt   = q_head.mag;
              status_nxt = ST_CLIPPED;
            end else begin
              if (!em_r && (tl_r != '0) && (fi_r == nts_r)) begin
                em_nxt   = 1'b1;
                pos_nxt  = '0;
                lfsr_nxt = LFSR_SEED;
                nts_nxt  = (nx > STRIDE_W'(FRAME_MAX)) ? FRAME_MAX : nx[FRAME_W-1:0];
              end
              if (em_nxt) begin
                fb        = lfsr_nxt[0] ^ lfsr_nxt[3];
                out_s_nxt = lfsr_nxt[0] ? {1'b0, cfg.amplitude}
                                        : (~{1'b0, cfg.amplitude} + 24'd1);
                lfsr_nxt  = {fb, lfsr_nxt[LFSR_W-1:1]};
                pos_nxt   = pos_nxt + POS_W'(1);
                if (pos_nxt >= POS_W'(STIMULUS_LENGTH)) begin
                  em_nxt  = 1'b0;
                  pos_nxt = '0;
                  tl_nxt  = tl_r - TRIALS_W'(1);
                end
              end
              fi_nxt = fi_inc;
              if (fi_inc >= total_r) begin
                status_nxt = ST_CAPTURED;
              end
            end
          end
        end
      end
      MODE_ARM: begin
        if (!active && (total != '0) && (total <= TOTAL_W'(MAX_CAPTURE_FRAMES))) begin
          acc_nxt    = 1'b1;
          status_nxt = ST_PREPARED;
          fi_nxt     = '0;
          total_nxt  = total[FRAME_W-1:0];
          nts_nxt    = cfg.pre_roll;
          tl_nxt     = TRIALS_W'(TRIAL_COUNT);
          pos_nxt    = '0;
          em_nxt     = 1'b0;
          lfsr_nxt   = LFSR_SEED;
          peak_nxt   = '0;
        end
      end
      MODE_CANCEL: begin
        if (active) begin
          status_nxt = ST_CANCELLED;
        end
      end
      MODE_CONFIG: begin
        if (active) begin
          status_nxt = ST_CONFIG;
        end
      end
      MODE_DEVICE: begin
        if (active) begin
          status_nxt = ST_DEVICE;
        end
      end
      MODE_RESET: begin
        if (!active) begin
          status_nxt = ST_IDLE;
          fi_nxt     = '0;
          peak_nxt   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= ST_IDLE;
      fi_r        <= '0;
      total_r     <= '0;
      nts_r       <= '0;
      tl_r        <= '0;
      pos_r       <= '0;
      em_r        <= 1'b0;
      lfsr_r      <= LFSR_SEED;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        status_r <= status_nxt;
        fi_r     <= fi_nxt;
        total_r  <= total_nxt;
        nts_r    <= nts_nxt;
        tl_r     <= tl_nxt;
        pos_r    <= pos_nxt;
        em_r     <= em_nxt;
        lfsr_r   <= lfsr_nxt;
        peak_r   <= peak_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_s_r <= out_s_nxt;
      cw_r    <= cw_nxt;
      caddr_r <= caddr_nxt;
      csamp_r <= csamp_nxt;
      acc_r   <= acc_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sample          = out_s_r;
  assign out_capture_write   = cw_r;
  assign out_capture_address = caddr_r;
  assign out_capture_sample  = csamp_r;
  assign out_arm_accepted    = acc_r;
  assign out_probe_status    = status_r;
  assign out_clip_peak       = peak_r;

endmodule

@@ rtl/core/mls_loopback_stimulus_capture_top.sv @@
// ----------------------------------------------------------------------------
// mls_loopback_stimulus_capture_top
// Loopback latency probe: arms a capture, drives an MLS stimulus per frame
// and hands out capture addresses and samples for external memory.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle while the output is not stalled; the
// result of an input transfer is held in the queue and then presented from
// the registered result stage. The rate is set by the probe state update in
// the back stage, which finishes a whole frame, arm or event for each item
// it takes; a two-entry queue between the input classifier and that stage
// lets either side stall on its own, and the input stalls only when the
// queue is full. Registers are written through the APB-style port at byte
// addresses 0, 4, 8 and 12 (amplitude, pre-roll, search window, clip level);
// they are read live, and since the clip level is applied as a transfer is
// taken, they should be written only while no transfer is in flight.
module mls_loopback_stimulus_capture_top
  import mlsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [23:0] in_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_sample,
  output logic        out_capture_write,
  output logic [21:0] out_capture_address,
  output logic [23:0] out_capture_sample,
  output logic        out_arm_accepted,
  output logic [2:0]  out_probe_status,
  output logic [23:0] out_clip_peak,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  item_t push_item;
  item_t head;
  logic  push, pop, q_full, q_not_empty;

  mlsp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mlsp_front u_front (
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_sample (in_sample),
    .q_full    (q_full),
    .cfg       (cfg),
    .in_stall  (in_stall),
    .push      (push),
    .item      (push_item)
  );

  mlsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  mlsp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .q_not_empty         (q_not_empty),
    .q_head              (head),
    .pop                 (pop),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_sample          (out_sample),
    .out_capture_write   (out_capture_write),
    .out_capture_address (out_capture_address),
    .out_capture_sample  (out_capture_sample),
    .out_arm_accepted    (out_arm_accepted),
    .out_probe_status    (out_probe_status),
    .out_clip_peak       (out_clip_peak)
  );

endmodule
